FILE: rtl/llpm_pkg.sv
package llpm_pkg;

    localparam int POOL_NODES_DEF = 64;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int VALUE_W        = 32;

    localparam logic [CMD_W-1:0] CMD_NEW = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

    // link store read address select
    localparam logic [1:0] RA_P  = 2'd0;
    localparam logic [1:0] RA_FH = 2'd1;
    localparam logic [1:0] RA_RD = 2'd2;

    // link store write address select
    localparam logic [1:0] WA_P  = 2'd0;
    localparam logic [1:0] WA_FH = 2'd1;
    localparam logic [1:0] WA_Q  = 2'd2;

    // link store write data select
    localparam logic [1:0] WD_NULL = 2'd0;
    localparam logic [1:0] WD_LP   = 2'd1;
    localparam logic [1:0] WD_FH   = 2'd2;
    localparam logic [1:0] WD_RD   = 2'd3;

    // result node index select
    localparam logic [1:0] IX_NONE = 2'd0;
    localparam logic [1:0] IX_FH   = 2'd1;
    localparam logic [1:0] IX_Q    = 2'd2;

    typedef struct packed {
        logic                in_load;
        logic                init_wr;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic [1:0]          wa_sel;
        logic [1:0]          wd_sel;
        logic                vwr_en;
        logic                lp_cap;
        logic                q_cap;
        logic                nfh_cap;
        logic                val_cap;
        logic                fh_load_rd;
        logic                fh_load_nfh;
        logic                fh_load_q;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_ix;
        logic                res_rm;
    } t_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             p_ok;
        logic             fh_ok;
        logic             rd_ok;
        logic             init_last;
    } t_sts;

endpackage

FILE: rtl/llpm_ram.sv
module llpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/llpm_ctrl.sv
module llpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           o_busy,
    input  llpm_pkg::t_sts i_sts,
    output llpm_pkg::t_ctl o_ctl
);

    import llpm_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_WR0  = 3'd3;
    localparam logic [2:0] S_RD1  = 3'd4;
    localparam logic [2:0] S_WRA  = 3'd5;
    localparam logic [2:0] S_WRB  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_ctl       ctl;

    always_comb begin
        ctl     = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                ctl.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    ctl.in_load = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                case (i_sts.cmd)
                    CMD_NEW: begin
                        if (!i_sts.fh_ok) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_EMPTY;
                        end else begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RA_FH;
                            n_state    = S_WR0;
                        end
                    end
                    CMD_INS: begin
                        if (!i_sts.p_ok) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_NULL;
                        end else if (!i_sts.fh_ok) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_EMPTY;
                        end else begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RA_P;
                            n_state    = S_RD1;
                        end
                    end
                    CMD_DEL: begin
                        if (!i_sts.p_ok) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = ST_NULL;
                        end else begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = RA_P;
                            n_state    = S_RD1;
                        end
                    end
                    default: begin
                        ctl.res_load   = 1'b1;
                        ctl.res_status = ST_OK;
                    end
                endcase
            end
            S_WR0: begin
                ctl.wr_en      = 1'b1;
                ctl.wa_sel     = WA_FH;
                ctl.wd_sel     = WD_NULL;
                ctl.vwr_en     = 1'b1;
                ctl.fh_load_rd = 1'b1;
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_OK;
                ctl.res_ix     = IX_FH;
                n_state        = S_IDLE;
            end
            S_RD1: begin
                if (i_sts.cmd == CMD_INS) begin
                    // hold link[p], fetch the next free node
                    ctl.lp_cap = 1'b1;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_FH;
                    n_state    = S_WRA;
                end else if (!i_sts.rd_ok) begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_NONE;
                    n_state        = S_IDLE;
                end else begin
                    // follower found: fetch its link and value
                    ctl.q_cap  = 1'b1;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_RD;
                    n_state    = S_WRA;
                end
            end
            S_WRA: begin
                ctl.wr_en = 1'b1;
                if (i_sts.cmd == CMD_INS) begin
                    ctl.wa_sel  = WA_FH;
                    ctl.wd_sel  = WD_LP;
                    ctl.vwr_en  = 1'b1;
                    ctl.nfh_cap = 1'b1;
                end else begin
                    ctl.wa_sel  = WA_P;
                    ctl.wd_sel  = WD_RD;
                    ctl.val_cap = 1'b1;
                end
                n_state = S_WRB;
            end
            S_WRB: begin
                ctl.wr_en      = 1'b1;
                ctl.wd_sel     = WD_FH;
                ctl.res_load   = 1'b1;
                ctl.res_status = ST_OK;
                if (i_sts.cmd == CMD_INS) begin
                    ctl.wa_sel      = WA_P;
                    ctl.fh_load_nfh = 1'b1;
                    ctl.res_ix      = IX_FH;
                end else begin
                    ctl.wa_sel    = WA_Q;
                    ctl.fh_load_q = 1'b1;
                    ctl.res_ix    = IX_Q;
                    ctl.res_rm    = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_ctl  = ctl;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !o_busy |=> o_busy)
        else $error("accepted beat did not raise busy");
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.res_load |=> !ctl.res_load)
        else $error("two results for one beat");
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !ctl.res_load && !ctl.wr_en)
        else $error("command activity during link init");
`endif

endmodule

FILE: rtl/llpm_datapath.sv
module llpm_datapath #(
    parameter int POOL_NODES = llpm_pkg::POOL_NODES_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  llpm_pkg::t_ctl                           i_ctl,
    output llpm_pkg::t_sts                           o_sts,
    input  logic [llpm_pkg::CMD_W-1:0]               i_cmd,
    input  logic signed [$clog2(POOL_NODES):0]       i_position,
    input  logic signed [llpm_pkg::VALUE_W-1:0]      i_value,
    output logic                                     o_done,
    output logic [llpm_pkg::STATUS_W-1:0]            o_status,
    output logic signed [$clog2(POOL_NODES):0]       o_node_index,
    output logic signed [llpm_pkg::VALUE_W-1:0]      o_removed_value
);

    import llpm_pkg::*;

    localparam int AW = $clog2(POOL_NODES);
    localparam int IW = AW + 1;
    localparam logic [IW-1:0] NULL_IDX  = '1;
    localparam logic [IW-1:0] POOL_LIM  = IW'(POOL_NODES);
    localparam logic [AW-1:0] LAST_NODE = AW'(POOL_NODES - 1);

    function automatic logic idx_ok(input logic [IW-1:0] a);
        return !a[IW-1] && ({1'b0, a[AW-1:0]} < POOL_LIM);
    endfunction

    logic [CMD_W-1:0]    r_cmd;
    logic [IW-1:0]       r_pos;
    logic [VALUE_W-1:0]  r_val_in;
    logic [IW-1:0]       r_fh;
    logic [IW-1:0]       r_lp;
    logic [IW-1:0]       r_q;
    logic [IW-1:0]       r_nfh;
    logic [VALUE_W-1:0]  r_rm;
    logic [AW-1:0]       r_init;
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [IW-1:0]       r_idx;
    logic [VALUE_W-1:0]  r_rmv;

    logic [IW-1:0]      link_rd;
    logic [VALUE_W-1:0] val_rd;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [IW-1:0]      wr_data;
    logic               link_wr_en;
    logic               val_rd_en;

    always_comb begin
        case (i_ctl.rd_sel)
            RA_P:    rd_addr = r_pos[AW-1:0];
            RA_FH:   rd_addr = r_fh[AW-1:0];
            RA_RD:   rd_addr = link_rd[AW-1:0];
            default: rd_addr = r_pos[AW-1:0];
        endcase
    end

    always_comb begin
        if (i_ctl.init_wr) begin
            wr_addr = r_init;
            wr_data = (r_init == LAST_NODE) ? NULL_IDX : ({1'b0, r_init} + IW'(1));
        end else begin
            case (i_ctl.wa_sel)
                WA_P:    wr_addr = r_pos[AW-1:0];
                WA_FH:   wr_addr = r_fh[AW-1:0];
                WA_Q:    wr_addr = r_q[AW-1:0];
                default: wr_addr = r_pos[AW-1:0];
            endcase
            case (i_ctl.wd_sel)
                WD_NULL: wr_data = NULL_IDX;
                WD_LP:   wr_data = r_lp;
                WD_FH:   wr_data = r_fh;
                WD_RD:   wr_data = link_rd;
                default: wr_data = NULL_IDX;
            endcase
        end
    end

    assign link_wr_en = i_ctl.wr_en || i_ctl.init_wr;
    assign val_rd_en  = i_ctl.rd_en && (i_ctl.rd_sel == RA_RD);

    llpm_ram #(
        .WIDTH (IW),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rd)
    );

    llpm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_NODES)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.vwr_en),
        .i_wr_addr (r_fh[AW-1:0]),
        .i_wr_data (r_val_in),
        .i_rd_en   (val_rd_en),
        .i_rd_addr (link_rd[AW-1:0]),
        .o_rd_data (val_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_fh   <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.init_wr) begin
                r_init <= r_init + AW'(1);
            end
            if (i_ctl.fh_load_rd) begin
                r_fh <= link_rd;
            end else if (i_ctl.fh_load_nfh) begin
                r_fh <= r_nfh;
            end else if (i_ctl.fh_load_q) begin
                r_fh <= r_q;
            end
            r_done <= i_ctl.res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.in_load) begin
            r_cmd    <= i_cmd;
            r_pos    <= i_position;
            r_val_in <= i_value;
        end
        if (i_ctl.lp_cap) begin
            r_lp <= link_rd;
        end
        if (i_ctl.q_cap) begin
            r_q <= link_rd;
        end
        if (i_ctl.nfh_cap) begin
            r_nfh <= link_rd;
        end
        if (i_ctl.val_cap) begin
            r_rm <= val_rd;
        end
        if (i_ctl.res_load) begin
            r_status <= i_ctl.res_status;
            case (i_ctl.res_ix)
                IX_FH:   r_idx <= r_fh;
                IX_Q:    r_idx <= r_q;
                default: r_idx <= NULL_IDX;
            endcase
            r_rmv <= i_ctl.res_rm ? r_rm : '0;
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.p_ok      = idx_ok(r_pos);
    assign o_sts.fh_ok     = idx_ok(r_fh);
    assign o_sts.rd_ok     = idx_ok(link_rd);
    assign o_sts.init_last = (r_init == LAST_NODE);

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_node_index    = r_idx;
    assign o_removed_value = r_rmv;

`ifndef SYNTHESIS
    a_fail_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_node_index == NULL_IDX) && (o_removed_value == '0))
        else $error("failed beat carries a node index or value");
    a_free_head_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fh[IW-1] |-> (r_fh == NULL_IDX))
        else $error("free head holds a malformed null");
`endif

endmodule

FILE: rtl/linked_list_pool_manager_core.sv
// Linked list node pool with a free list.
// Input channel: drive i_cmd, i_position and i_value with start high; the beat
// is taken at a rising edge where start is high and busy is low.
// Result channel: o_done is high for one cycle with o_status, o_node_index and
// o_removed_value; the result must be taken in that cycle, there is no stall.
// Path from the accept edge to o_done, by command:
//   - null position, pool empty, unused command: result from the decode state
//   - new head: decode, then write; delete with no follower: decode, then read
//   - insert after, delete after: decode, read, then write A and write B
// The paths follow from the single read port of the link store and its
// registered read: each command that writes reads one or two links first.
// busy drops in the cycle o_done rises, so the next beat may be taken then.
// After reset the link store is filled with the initial free chain, one entry
// a cycle, with busy high until every entry is written; no beat is taken until then.
// The value store is not cleared; a node's value is defined once written.
module linked_list_pool_manager_core #(
    parameter int POOL_NODES = llpm_pkg::POOL_NODES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [llpm_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [$clog2(POOL_NODES):0]  i_position,
    input  logic signed [llpm_pkg::VALUE_W-1:0] i_value,
    output logic                                o_done,
    output logic [llpm_pkg::STATUS_W-1:0]       o_status,
    output logic signed [$clog2(POOL_NODES):0]  o_node_index,
    output logic signed [llpm_pkg::VALUE_W-1:0] o_removed_value
);

    import llpm_pkg::*;

    t_ctl ctl;
    t_sts sts;

    llpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    llpm_datapath #(
        .POOL_NODES (POOL_NODES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cmd           (i_cmd),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_node_index    (o_node_index),
        .o_removed_value (o_removed_value)
    );

endmodule
